/* rtl/ffca_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and codes for the first-fit coalescing heap allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT   = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ZERO_SIZE  = 3'd1;
  localparam status_t ST_NO_SPACE   = 3'd2;
  localparam status_t ST_NOT_ALLOC  = 3'd3;
  localparam status_t ST_TABLE_FULL = 3'd4;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_A_SCAN,
    S_A_HIT,
    S_A_FIN,
    S_F_RD,
    S_F_SCAN,
    S_F_APPLY,
    S_F_INS,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_DONE,
    P_ALLOC_FIN,
    P_INSERT
  } post_t;

endpackage

/* rtl/ffca_table_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_table_mem
// Free table memory: block start and size per entry, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module ffca_table_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wstart,
  input  logic [DW-1:0] wsize,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rstart,
  output logic [DW-1:0] rsize
);

  logic [2*DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wstart, wsize};
    end
    {rstart, rsize} <= mem[raddr];
  end

endmodule

/* rtl/ffca_store_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_store_mem
// Block store: allocated mark and block size per aligned heap slot, one write
// and one registered read per cycle.
// ----------------------------------------------------------------------------
module ffca_store_mem #(
  parameter int DEPTH = 8193,
  parameter int AW    = 14,
  parameter int DW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wmark,
  input  logic [DW-1:0] wsize,
  input  logic [AW-1:0] raddr,
  output logic          rmark,
  output logic [DW-1:0] rsize
);

  logic [DW:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wmark, wsize};
    end
    {rmark, rsize} <= mem[raddr];
  end

endmodule

/* rtl/first_fit_coalescing_heap_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_heap_allocator
// First-fit heap allocator with an address-sorted, coalescing free table.
//
// Requests enter on the in_ channel (in_valid / in_stall); one result per
// request leaves on the out_ channel (out_valid / out_stall). Registers are
// written on the cfg_ channel (cfg_valid / cfg_ready, always ready).
// One request is processed at a time; the free table is read one entry per
// cycle. Zero-size, oversize and bad-address requests go straight to the
// result; a free first reads the block store and ends there for an
// unallocated slot. An allocate scans the table for the first entry that
// fits and splits it, or takes it whole and shifts the later entries down;
// a free scans for its neighbours, then inserts an entry after shifting the
// later ones up, grows one neighbour, or merges both and shifts the rest
// down. in_stall drops at the edge that registers the result.
// After reset and after every heap_length write, a clearing pass walks all
// HEAP_BYTES / ALIGN_BYTES + 1 block-store slots (8193 by default), one slot
// a cycle; in_stall stays high during it.
// The result register frees the request side: a new request is accepted
// while a finished result waits for out_stall to drop.
// ----------------------------------------------------------------------------
module first_fit_coalescing_heap_allocator #(
  parameter int HEAP_BYTES      = 65536,
  parameter int ALIGN_BYTES     = 8,
  parameter int HEADER_BYTES    = 8,
  parameter int MAX_FREE_BLOCKS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_operation,
  input  logic [16:0]                       in_wanted_size,
  input  logic [15:0]                       in_block_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ffca_pkg::status_t                 out_status,
  output logic [15:0]                       out_user_address,
  output logic [16:0]                       out_free_bytes,
  output logic [16:0]                       out_min_free_bytes,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffca_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import ffca_pkg::*;

  localparam int HDR    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int ALG    = $clog2(ALIGN_BYTES);
  localparam int SDEPTH = HEAP_BYTES / ALIGN_BYTES + 1;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int OW     = $clog2(HEAP_BYTES + 1);
  localparam int CW     = ((OW > 17) ? OW : 17) + 2;
  localparam int TAW    = $clog2(MAX_FREE_BLOCKS);
  localparam int CNW    = $clog2(MAX_FREE_BLOCKS + 1);

  localparam logic [CW-1:0]  HDR_C   = CW'(HDR);
  localparam logic [CW-1:0]  AMASK   = CW'(ALIGN_BYTES - 1);
  localparam logic [CW-1:0]  HEAP_C  = CW'(HEAP_BYTES);
  localparam logic [CW-1:0]  SDEP_C  = CW'(SDEPTH);
  localparam logic [CNW-1:0] MAX_C   = CNW'(MAX_FREE_BLOCKS);
  localparam logic [SAW-1:0] SLAST_C = SAW'(SDEPTH - 1);

  state_t          state_r, state_nxt;
  post_t           post_r, post_nxt;
  logic [16:0]     heap_size_r, heap_size_nxt;
  logic [12:0]     min_split_r, min_split_nxt;
  logic [CNW-1:0]  count_r, count_nxt;
  logic [OW-1:0]   total_r, total_nxt;
  logic [OW-1:0]   low_r, low_nxt;
  logic [SAW-1:0]  clr_r, clr_nxt;
  logic [CW-1:0]   need_r, need_nxt;
  logic [OW-1:0]   start_r, start_nxt;
  logic [SAW-1:0]  sidx_r, sidx_nxt;
  logic [OW-1:0]   bsize_r, bsize_nxt;
  logic [CNW-1:0]  scan_r, scan_nxt;
  logic            pend_r, pend_nxt;
  logic [TAW-1:0]  pidx_r, pidx_nxt;
  logic [OW-1:0]   hs_r, hs_nxt;
  logic [OW-1:0]   hz_r, hz_nxt;
  logic [CNW-1:0]  pos_r, pos_nxt;
  logic            prev_v_r, prev_v_nxt;
  logic [OW-1:0]   prev_s_r, prev_s_nxt;
  logic [OW-1:0]   prev_z_r, prev_z_nxt;
  logic            nv_r, nv_nxt;
  logic [OW-1:0]   ns_r, ns_nxt;
  logic [OW-1:0]   nz_r, nz_nxt;
  logic            sh_up_r, sh_up_nxt;
  logic [TAW-1:0]  sh_rd_r, sh_rd_nxt;
  logic [CNW-1:0]  sh_cnt_r, sh_cnt_nxt;
  status_t         res_st_r, res_st_nxt;
  logic [15:0]     res_ua_r, res_ua_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_st_r, out_st_nxt;
  logic [15:0]     out_ua_r, out_ua_nxt;
  logic [16:0]     out_fb_r, out_fb_nxt;
  logic [16:0]     out_mf_r, out_mf_nxt;

  logic            tw_en;
  logic [TAW-1:0]  tw_addr, tr_addr;
  logic [OW-1:0]   tw_s, tw_z, tr_s, tr_z;
  logic            sw_en, sw_mark, sr_mark;
  logic [SAW-1:0]  sw_addr, sr_addr;
  logic [OW-1:0]   sw_size, sr_size;

  logic [CW-1:0]   len_c, usable_c, need_c, ua_c, fst_c, diff_c, tsum_c;
  logic            merge_p, merge_n, bad_free;

  ffca_table_mem #(.DEPTH(MAX_FREE_BLOCKS), .AW(TAW), .DW(OW)) u_table (
    .clk(clk), .we(tw_en), .waddr(tw_addr), .wstart(tw_s), .wsize(tw_z),
    .raddr(tr_addr), .rstart(tr_s), .rsize(tr_z)
  );

  ffca_store_mem #(.DEPTH(SDEPTH), .AW(SAW), .DW(OW)) u_store (
    .clk(clk), .we(sw_en), .waddr(sw_addr), .wmark(sw_mark), .wsize(sw_size),
    .raddr(sr_addr), .rmark(sr_mark), .rsize(sr_size)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      post_r      <= P_DONE;
      heap_size_r <= 17'd65536;
      min_split_r <= 13'd16;
      count_r     <= '0;
      total_r     <= '0;
      low_r       <= '0;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      post_r      <= post_nxt;
      heap_size_r <= heap_size_nxt;
      min_split_r <= min_split_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      low_r       <= low_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r   <= need_nxt;
    start_r  <= start_nxt;
    sidx_r   <= sidx_nxt;
    bsize_r  <= bsize_nxt;
    scan_r   <= scan_nxt;
    pidx_r   <= pidx_nxt;
    hs_r     <= hs_nxt;
    hz_r     <= hz_nxt;
    pos_r    <= pos_nxt;
    prev_v_r <= prev_v_nxt;
    prev_s_r <= prev_s_nxt;
    prev_z_r <= prev_z_nxt;
    nv_r     <= nv_nxt;
    ns_r     <= ns_nxt;
    nz_r     <= nz_nxt;
    sh_up_r  <= sh_up_nxt;
    sh_rd_r  <= sh_rd_nxt;
    sh_cnt_r <= sh_cnt_nxt;
    res_st_r <= res_st_nxt;
    res_ua_r <= res_ua_nxt;
    out_st_r <= out_st_nxt;
    out_ua_r <= out_ua_nxt;
    out_fb_r <= out_fb_nxt;
    out_mf_r <= out_mf_nxt;
  end

  always_comb begin
    len_c    = (CW'(heap_size_r) > HEAP_C) ? HEAP_C : CW'(heap_size_r);
    usable_c = (len_c >= HDR_C) ? ((len_c - HDR_C) & ~AMASK) : '0;
    need_c   = (CW'(in_wanted_size) + HDR_C + AMASK) & ~AMASK;
    ua_c     = CW'(in_block_address);
    fst_c    = ua_c - HDR_C;
    bad_free = (ua_c < HDR_C) || ((fst_c & AMASK) != '0) || ((fst_c >> ALG) >= SDEP_C);
    diff_c   = CW'(hz_r) - need_r;
    merge_p  = prev_v_r && (CW'(prev_s_r) + CW'(prev_z_r) == CW'(start_r));
    merge_n  = nv_r && (CW'(start_r) + CW'(bsize_r) == CW'(ns_r));
    tsum_c   = CW'(prev_z_r) + CW'(bsize_r) + (merge_n ? CW'(nz_r) : '0);

    state_nxt     = state_r;
    post_nxt      = post_r;
    heap_size_nxt = heap_size_r;
    min_split_nxt = min_split_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    low_nxt       = low_r;
    clr_nxt       = clr_r;
    need_nxt      = need_r;
    start_nxt     = start_r;
    sidx_nxt      = sidx_r;
    bsize_nxt     = bsize_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    hs_nxt        = hs_r;
    hz_nxt        = hz_r;
    pos_nxt       = pos_r;
    prev_v_nxt    = prev_v_r;
    prev_s_nxt    = prev_s_r;
    prev_z_nxt    = prev_z_r;
    nv_nxt        = nv_r;
    ns_nxt        = ns_r;
    nz_nxt        = nz_r;
    sh_up_nxt     = sh_up_r;
    sh_rd_nxt     = sh_rd_r;
    sh_cnt_nxt    = sh_cnt_r;
    res_st_nxt    = res_st_r;
    res_ua_nxt    = res_ua_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt    = out_st_r;
    out_ua_nxt    = out_ua_r;
    out_fb_nxt    = out_fb_r;
    out_mf_nxt    = out_mf_r;

    tw_en   = 1'b0;
    tw_addr = '0;
    tw_s    = '0;
    tw_z    = '0;
    tr_addr = scan_r[TAW-1:0];
    sw_en   = 1'b0;
    sw_addr = sidx_r;
    sw_mark = 1'b0;
    sw_size = bsize_r;
    sr_addr = SAW'(fst_c >> ALG);
    in_stall = (state_r != S_IDLE);

    case (state_r)
      S_CLR: begin
        sw_en   = 1'b1;
        sw_addr = clr_r;
        if (clr_r == '0) begin
          tw_en     = 1'b1;
          tw_addr   = '0;
          tw_s      = '0;
          tw_z      = OW'(usable_c);
          count_nxt = (usable_c != '0) ? CNW'(1) : '0;
          total_nxt = OW'(usable_c);
          low_nxt   = OW'(usable_c);
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLAST_C) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          scan_nxt   = '0;
          prev_v_nxt = 1'b0;
          res_ua_nxt = '0;
          need_nxt   = need_c;
          if (in_operation == OP_ALLOC) begin
            if (in_wanted_size == '0) begin
              res_st_nxt = ST_ZERO_SIZE;
              state_nxt  = S_DONE;
            end else if (need_c > CW'(total_r)) begin
              res_st_nxt = ST_NO_SPACE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_A_SCAN;
            end
          end else begin
            start_nxt = OW'(fst_c);
            sidx_nxt  = SAW'(fst_c >> ALG);
            if (bad_free) begin
              res_st_nxt = ST_NOT_ALLOC;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_F_RD;
            end
          end
        end
      end

      S_A_SCAN: begin
        if (pend_r && (CW'(tr_z) >= need_r)) begin
          hs_nxt    = tr_s;
          hz_nxt    = tr_z;
          pidx_nxt  = pidx_r;
          state_nxt = S_A_HIT;
        end else if (scan_r >= count_r) begin
          res_st_nxt = ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          pend_nxt = 1'b1;
          pidx_nxt = scan_r[TAW-1:0];
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_A_HIT: begin
        start_nxt = hs_r;
        sidx_nxt  = SAW'(hs_r >> ALG);
        if (diff_c > CW'(min_split_r)) begin
          tw_en     = 1'b1;
          tw_addr   = pidx_r;
          tw_s      = OW'(CW'(hs_r) + need_r);
          tw_z      = OW'(diff_c);
          bsize_nxt = OW'(need_r);
          state_nxt = S_A_FIN;
        end else begin
          bsize_nxt  = hz_r;
          count_nxt  = count_r - 1'b1;
          sh_up_nxt  = 1'b0;
          sh_rd_nxt  = pidx_r + 1'b1;
          sh_cnt_nxt = count_r - 1'b1 - CNW'(pidx_r);
          post_nxt   = P_ALLOC_FIN;
          state_nxt  = S_SHIFT;
        end
      end

      S_A_FIN: begin
        sw_en      = 1'b1;
        sw_mark    = 1'b1;
        total_nxt  = total_r - bsize_r;
        if ((total_r - bsize_r) < low_r) begin
          low_nxt = total_r - bsize_r;
        end
        res_st_nxt = ST_OK;
        res_ua_nxt = 16'(CW'(start_r) + HDR_C);
        state_nxt  = S_DONE;
      end

      S_F_RD: begin
        if (!sr_mark) begin
          res_st_nxt = ST_NOT_ALLOC;
          state_nxt  = S_DONE;
        end else begin
          bsize_nxt = sr_size;
          state_nxt = S_F_SCAN;
        end
      end

      S_F_SCAN: begin
        if (pend_r && (tr_s >= start_r)) begin
          pos_nxt   = CNW'(pidx_r);
          nv_nxt    = 1'b1;
          ns_nxt    = tr_s;
          nz_nxt    = tr_z;
          state_nxt = S_F_APPLY;
        end else begin
          if (pend_r) begin
            prev_v_nxt = 1'b1;
            prev_s_nxt = tr_s;
            prev_z_nxt = tr_z;
          end
          if (scan_r >= count_r) begin
            pos_nxt   = count_r;
            nv_nxt    = 1'b0;
            state_nxt = S_F_APPLY;
          end else begin
            pend_nxt = 1'b1;
            pidx_nxt = scan_r[TAW-1:0];
            scan_nxt = scan_r + 1'b1;
          end
        end
      end

      S_F_APPLY: begin
        if (!merge_p && !merge_n && (count_r >= MAX_C)) begin
          res_st_nxt = ST_TABLE_FULL;
          state_nxt  = S_DONE;
        end else begin
          sw_en      = 1'b1;
          sw_mark    = 1'b0;
          total_nxt  = total_r + bsize_r;
          res_st_nxt = ST_OK;
          state_nxt  = S_DONE;
          if (merge_p) begin
            tw_en   = 1'b1;
            tw_addr = TAW'(pos_r - 1'b1);
            tw_s    = prev_s_r;
            tw_z    = OW'(tsum_c);
            if (merge_n) begin
              count_nxt  = count_r - 1'b1;
              sh_up_nxt  = 1'b0;
              sh_rd_nxt  = TAW'(pos_r + 1'b1);
              sh_cnt_nxt = count_r - 1'b1 - pos_r;
              post_nxt   = P_DONE;
              state_nxt  = S_SHIFT;
            end
          end else if (merge_n) begin
            tw_en   = 1'b1;
            tw_addr = TAW'(pos_r);
            tw_s    = start_r;
            tw_z    = nz_r + bsize_r;
          end else begin
            sh_up_nxt  = 1'b1;
            sh_rd_nxt  = TAW'(count_r - 1'b1);
            sh_cnt_nxt = count_r - pos_r;
            post_nxt   = P_INSERT;
            state_nxt  = S_SHIFT;
          end
        end
      end

      S_F_INS: begin
        tw_en     = 1'b1;
        tw_addr   = TAW'(pos_r);
        tw_s      = start_r;
        tw_z      = bsize_r;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_SHIFT: begin
        tr_addr = sh_rd_r;
        if (pend_r) begin
          tw_en   = 1'b1;
          tw_addr = sh_up_r ? (pidx_r + 1'b1) : (pidx_r - 1'b1);
          tw_s    = tr_s;
          tw_z    = tr_z;
        end
        if (sh_cnt_r != '0) begin
          pend_nxt   = 1'b1;
          pidx_nxt   = sh_rd_r;
          sh_rd_nxt  = sh_up_r ? (sh_rd_r - 1'b1) : (sh_rd_r + 1'b1);
          sh_cnt_nxt = sh_cnt_r - 1'b1;
        end else if (!pend_r) begin
          case (post_r)
            P_ALLOC_FIN: state_nxt = S_A_FIN;
            P_INSERT:    state_nxt = S_F_INS;
            P_DONE:      state_nxt = S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_ua_nxt    = res_ua_r;
          out_fb_nxt    = 17'(total_r);
          out_mf_nxt    = 17'(low_r);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_HEAP_LENGTH: begin
          heap_size_nxt = cfg_data;
          clr_nxt       = '0;
          state_nxt     = S_CLR;
        end
        REG_MIN_SPLIT: min_split_nxt = cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_status         = out_st_r;
  assign out_user_address   = out_ua_r;
  assign out_free_bytes     = out_fb_r;
  assign out_min_free_bytes = out_mf_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("free table count beyond capacity");

  a_low_water: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= total_r)
    else $error("low water above free total");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && tw_en) |-> CNW'(tw_addr) <= count_r)
    else $error("shift writes beyond table fill");

endmodule
